// File: rtl/core/lclb_pkg.sv
// Shared constants and types for the line-aware circular log buffer.
// Depends on nothing; imported by the log buffer core and the testbench.
`default_nettype none
package lclb_pkg;
	localparam int DEPTH = 4096;
	localparam int AW    = $clog2(DEPTH);
	localparam int CLB_W = AW + 1;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_READ   = 3'd1,
		OP_PEEK   = 3'd2,
		OP_SEEK   = 3'd3,
		OP_REWIND = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_W_FIN   = 7'b0000010,
		ST_EV_RD   = 7'b0000100,
		ST_EV_CHK  = 7'b0001000,
		ST_RD_DATA = 7'b0010000,
		ST_SK_RD   = 7'b0100000,
		ST_SK_CHK  = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

// File: rtl/core/line_aware_circular_log_buffer.sv
// Line-aware circular log buffer: byte ring of whole CR LF lines.
// Depends on lclb_pkg and lclb_ram.
// Steps: rewind, clear and empty reads finish from idle; read/peek pass through RD_DATA; write
// runs EV_RD/EV_CHK per evicted byte, then W_FIN; seek runs SK_RD/SK_CHK per byte scanned.
// One item at a time, set by the single RAM read port.
// The result is shown for one cycle on done; the receiver cannot stall.
// Reset (arst_n low) clears all pointers and counters; the byte store is not cleared.
`default_nettype none
module line_aware_circular_log_buffer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  data_byte,
	input  wire logic [31:0] from_line,
	output logic             done,
	output logic [7:0]       read_byte,
	output logic             byte_valid,
	output logic [11:0]      bytes_available,
	output logic [11:0]      bytes_used,
	output logic [31:0]      range_start_line,
	output logic [31:0]      range_end_line
);
	import lclb_pkg::*;

	state_t            state_q;
	logic [AW-1:0]     wp_q, old_q, rp_q, rep_q, pos_q, mark_q;
	logic [31:0]       old_line_q, comp_line_q, skip_q, seek_line_q;
	logic [CLB_W-1:0]  clb_q;
	logic [7:0]        prev_q, data_q, rbyte_q;
	logic              valid_q, seeked_q, peek_q, cr_q, done_q;

	logic              accept;
	logic              we;
	logic [AW-1:0]     raddr;
	logic [7:0]        rdata;
	logic [AW-1:0]     wp_inc, old_inc, pos_inc;
	logic [31:0]       from_cl;

	assign accept  = start && (state_q == ST_IDLE);
	assign we      = accept && (op_t'(opcode) == OP_WRITE);
	assign wp_inc  = wp_q + 1'b1;
	assign old_inc = old_q + 1'b1;
	assign pos_inc = pos_q + 1'b1;
	assign from_cl = (from_line < old_line_q) ? old_line_q : from_line;

	always_comb begin
		case (state_q)
			ST_EV_RD: raddr = old_q;
			ST_SK_RD: raddr = pos_q;
			default:  raddr = rp_q;
		endcase
	end

	lclb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (data_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			old_q       <= '0;
			rp_q        <= '0;
			rep_q       <= '0;
			pos_q       <= '0;
			mark_q      <= '0;
			old_line_q  <= '0;
			comp_line_q <= '0;
			skip_q      <= '0;
			seek_line_q <= '0;
			clb_q       <= '0;
			prev_q      <= '0;
			data_q      <= '0;
			rbyte_q     <= '0;
			valid_q     <= 1'b0;
			seeked_q    <= 1'b0;
			peek_q      <= 1'b0;
			cr_q        <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						rbyte_q  <= '0;
						valid_q  <= 1'b0;
						seeked_q <= 1'b0;
						case (op_t'(opcode))
							OP_WRITE: begin
								wp_q   <= wp_inc;
								data_q <= data_byte;
								if (clb_q < CLB_W'(DEPTH)) begin
									clb_q <= clb_q + 1'b1;
								end
								if (wp_inc == old_q) begin
									old_line_q <= old_line_q + 1'b1;
									state_q    <= ST_EV_RD;
								end else begin
									state_q <= ST_W_FIN;
								end
							end
							OP_READ, OP_PEEK: begin
								peek_q <= (op_t'(opcode) == OP_PEEK);
								if (rp_q != rep_q) begin
									state_q <= ST_RD_DATA;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_SEEK: begin
								seeked_q <= 1'b1;
								if (wp_q == old_q) begin
									rp_q        <= old_q;
									rep_q       <= wp_q;
									seek_line_q <= old_line_q;
									done_q      <= 1'b1;
								end else if (from_cl >= comp_line_q) begin
									rp_q        <= wp_q;
									rep_q       <= wp_q;
									seek_line_q <= comp_line_q;
									done_q      <= 1'b1;
								end else begin
									seek_line_q <= from_cl;
									skip_q      <= from_cl - old_line_q;
									pos_q       <= old_q;
									mark_q      <= old_q;
									cr_q        <= 1'b0;
									if (from_cl == old_line_q) begin
										rp_q   <= old_q;
										rep_q  <= wp_q;
										done_q <= 1'b1;
									end else begin
										state_q <= ST_SK_RD;
									end
								end
							end
							OP_REWIND: begin
								rp_q   <= old_q;
								rep_q  <= wp_q;
								done_q <= 1'b1;
							end
							OP_CLEAR: begin
								wp_q        <= '0;
								old_q       <= '0;
								rp_q        <= '0;
								rep_q       <= '0;
								old_line_q  <= '0;
								comp_line_q <= '0;
								clb_q       <= '0;
								prev_q      <= '0;
								done_q      <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_EV_RD: begin
					state_q <= ST_EV_CHK;
				end
				ST_EV_CHK: begin
					// push read pointers off the dropped byte
					if (rp_q == old_q) begin
						rp_q <= old_inc;
					end
					if (rep_q == old_q) begin
						rep_q <= old_inc;
					end
					old_q <= old_inc;
					if (rdata == CH_LF || old_inc == wp_q) begin
						state_q <= ST_W_FIN;
					end else begin
						state_q <= ST_EV_RD;
					end
				end
				ST_W_FIN: begin
					if (prev_q == CH_CR && data_q == CH_LF) begin
						comp_line_q <= comp_line_q + 1'b1;
						// overlong line: empty the ring
						if (clb_q >= CLB_W'(DEPTH)) begin
							old_q      <= wp_q;
							old_line_q <= comp_line_q + 1'b1;
							rp_q       <= wp_q;
							rep_q      <= wp_q;
						end
						clb_q <= '0;
					end
					prev_q  <= data_q;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RD_DATA: begin
					rbyte_q <= rdata;
					valid_q <= 1'b1;
					if (!peek_q) begin
						rp_q <= rp_q + 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SK_RD: begin
					// no further line end: hold the window at the last line start found
					if (pos_q == wp_q) begin
						rp_q    <= mark_q;
						rep_q   <= wp_q;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SK_CHK;
					end
				end
				ST_SK_CHK: begin
					pos_q <= pos_inc;
					if (cr_q && rdata == CH_LF) begin
						cr_q   <= 1'b0;
						mark_q <= pos_inc;
						skip_q <= skip_q - 1'b1;
						if (skip_q == 32'd1) begin
							rp_q    <= pos_inc;
							rep_q   <= wp_q;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SK_RD;
						end
					end else begin
						cr_q    <= (rdata == CH_CR);
						state_q <= ST_SK_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy             = (state_q != ST_IDLE);
	assign done             = done_q;
	assign read_byte        = rbyte_q;
	assign byte_valid       = valid_q;
	assign bytes_available  = 12'(rep_q - rp_q);
	assign bytes_used       = 12'(wp_q - old_q);
	assign range_start_line = seeked_q ? seek_line_q : old_line_q;
	assign range_end_line   = comp_line_q;
endmodule
`default_nettype wire

// File: rtl/core/lclb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lclb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the line-aware circular log buffer.
// Depends on lclb_pkg and the line_aware_circular_log_buffer RTL; a scoreboard
// class tracks the ring and checks every result beat.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lclb_pkg::*;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_ITEMS = 900;

	typedef struct packed {
		logic [7:0]  rbyte;
		logic        valid;
		logic [11:0] avail;
		logic [11:0] used;
		logic [31:0] start_line;
		logic [31:0] end_line;
	} ring_status_t;

	class line_ring_tracker;
		logic [7:0]       ram [DEPTH];
		logic [AW-1:0]    wr, old, rd, rend;
		logic [31:0]      old_line, done_line;
		logic [CLB_W-1:0] line_bytes;
		logic [7:0]       prev;
		ring_status_t     expected_status[$];
		int               errors;

		function new();
			errors = 0;
			clear_all();
		endfunction

		function void clear_all();
			wr = '0; old = '0; rd = '0; rend = '0;
			old_line = '0; done_line = '0; line_bytes = '0; prev = '0;
		endfunction

		// search for the byte after the next CR LF, stopping at the write pointer
		function bit find_line_end(input logic [AW-1:0] p, output logic [AW-1:0] e);
			int guard;
			logic [AW-1:0] nx;
			guard = 0;
			e = p;
			while (p != wr && guard < DEPTH) begin
				nx = p + 1'b1;
				if (ram[p] == CH_CR && nx != wr && ram[nx] == CH_LF) begin
					e = nx + 1'b1;
					return 1'b1;
				end
				p = p + 1'b1;
				guard++;
			end
			return 1'b0;
		endfunction

		function void write_byte(logic [7:0] c);
			logic [7:0] last;
			ram[wr] = c;
			wr = wr + 1'b1;
			if (line_bytes < DEPTH)
				line_bytes++;
			if (wr == old) begin
				// ring full: drop the oldest line up to its LF
				old_line++;
				do begin
					if (rd == old)
						rd = old + 1'b1;
					if (rend == old)
						rend = old + 1'b1;
					last = ram[old];
					old = old + 1'b1;
					if (last == CH_LF)
						break;
				end while (old != wr);
			end
			if (prev == CH_CR && c == CH_LF) begin
				done_line++;
				if (line_bytes >= DEPTH) begin
					old = wr; rd = wr; rend = wr;
					old_line = done_line;
				end
				line_bytes = '0;
			end
			prev = c;
		endfunction

		function logic [31:0] seek_line(logic [31:0] f);
			logic [AW-1:0] p, e;
			logic [31:0] skip;
			if (wr == old) begin
				rd = old; rend = wr;
				return old_line;
			end
			if (f < old_line)
				f = old_line;
			if (f >= done_line) begin
				rd = wr; rend = wr;
				return done_line;
			end
			skip = f - old_line;
			p = old;
			for (longint i = 0; i < skip; i++) begin
				if (!find_line_end(p, e))
					break;
				p = e;
			end
			rd = p; rend = wr;
			return f;
		endfunction

		function void note_op(logic [2:0] op, logic [7:0] d, logic [31:0] f);
			ring_status_t s;
			logic seeked;
			s = '0;
			seeked = 1'b0;
			case (op)
				OP_WRITE: write_byte(d);
				OP_READ, OP_PEEK: begin
					if (rd != rend) begin
						s.rbyte = ram[rd];
						s.valid = 1'b1;
						if (op == OP_READ)
							rd = rd + 1'b1;
					end
				end
				OP_SEEK: begin
					s.start_line = seek_line(f);
					seeked = 1'b1;
				end
				OP_REWIND: begin
					rd = old; rend = wr;
				end
				OP_CLEAR: clear_all();
				default: ;
			endcase
			if (!seeked)
				s.start_line = old_line;
			s.avail = rend - rd;
			s.used = wr - old;
			s.end_line = done_line;
			expected_status.push_back(s);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_status(ring_status_t got);
			ring_status_t want;
			if (expected_status.size() == 0) begin
				report("result with nothing pending", got.end_line, 0);
				return;
			end
			want = expected_status.pop_front();
			if (got.rbyte != want.rbyte)
				report("read_byte", got.rbyte, want.rbyte);
			if (got.valid != want.valid)
				report("byte_valid", got.valid, want.valid);
			if (got.avail != want.avail)
				report("bytes_available", got.avail, want.avail);
			if (got.used != want.used)
				report("bytes_used", got.used, want.used);
			if (got.start_line != want.start_line)
				report("range_start_line", got.start_line, want.start_line);
			if (got.end_line != want.end_line)
				report("range_end_line", got.end_line, want.end_line);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  opcode = OP_WRITE;
	logic [7:0]  data_byte = '0;
	logic [31:0] from_line = '0;
	logic        busy, done, byte_valid;
	logic [7:0]  read_byte;
	logic [11:0] bytes_available, bytes_used;
	logic [31:0] range_start_line, range_end_line;

	line_ring_tracker sb = new();
	int cycles = 0;
	int burst_left = 0;
	int items = 0;

	line_aware_circular_log_buffer uut (
		.clk, .arst_n, .start, .busy, .opcode, .data_byte, .from_line, .done,
		.read_byte, .byte_valid, .bytes_available, .bytes_used,
		.range_start_line, .range_end_line
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_status('{read_byte, byte_valid, bytes_available, bytes_used,
				range_start_line, range_end_line});
	end

	// send one beat; start is held high across a burst
	task automatic issue(logic [2:0] op, logic [7:0] d, logic [31:0] f);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 20);
		end
		start <= 1'b1;
		opcode <= op;
		data_byte <= d;
		from_line <= f;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_op(op, d, f);
		burst_left--;
		items++;
	endtask

	task automatic put(logic [7:0] d);
		issue(OP_WRITE, d, $urandom());
	endtask

	task automatic put_line(int len, bit any_byte);
		for (int i = 0; i < len; i++)
			put(any_byte ? 8'($urandom()) : 8'($urandom_range(8'h20, 8'h7e)));
		put(CH_CR);
		put(CH_LF);
	endtask

	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		while (sb.expected_status.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] near_line();
		return sb.old_line + $urandom_range(0, sb.done_line - sb.old_line + 3) - 2;
	endfunction

	task automatic single_op();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			issue(OP_READ, $urandom(), $urandom());
		else if (pick < 55)
			issue(OP_PEEK, $urandom(), $urandom());
		else if (pick < 75)
			issue(OP_SEEK, $urandom(), ($urandom_range(0, 4) == 0) ? $urandom() : near_line());
		else if (pick < 88)
			issue(OP_REWIND, $urandom(), $urandom());
		else if (pick < 92)
			issue(OP_CLEAR, $urandom(), $urandom());
		else if (pick < 96)
			issue(OP_SPARE6, $urandom(), $urandom());
		else
			issue(OP_SPARE7, $urandom(), $urandom());
	endtask

	initial begin
		int written;
		bit paused;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, extremes, seek corner cases, spare opcodes
		issue(OP_READ, 8'hff, 32'hffff_ffff);
		issue(OP_SEEK, 8'h00, 32'd5);
		issue(OP_SPARE6, 8'h00, 32'h0);
		issue(OP_SPARE7, 8'hff, 32'hffff_ffff);
		put(8'h00); put(8'hff); put(CH_CR); put(CH_LF);
		put(8'h41); put(CH_LF); put(CH_CR); put(8'h42); put(CH_CR); put(CH_LF);
		put(8'h43);
		issue(OP_PEEK, 8'h00, 32'h0);
		issue(OP_READ, 8'h00, 32'h0);
		issue(OP_SEEK, 8'h00, 32'd1);
		issue(OP_READ, 8'h00, 32'h0);
		issue(OP_SEEK, 8'h00, 32'd2);
		issue(OP_SEEK, 8'h00, 32'hffff_ffff);
		issue(OP_REWIND, 8'h00, 32'h0);
		issue(OP_READ, 8'h00, 32'h0);
		issue(OP_CLEAR, 8'h00, 32'h0);
		issue(OP_READ, 8'h00, 32'h0);

		// fill past the ring so oldest lines are dropped under a live window
		written = 0;
		while (written < DEPTH + 600) begin
			int len;
			len = $urandom_range(0, 80);
			put_line(len, $urandom_range(0, 7) == 0);
			written += len + 2;
			if ($urandom_range(0, 3) == 0)
				single_op();
		end
		issue(OP_SEEK, 8'h00, 32'h0);
		issue(OP_SEEK, 8'h00, sb.old_line + 3);
		for (int i = 0; i < 4; i++)
			issue(OP_READ, $urandom(), $urandom());
		// a line longer than the ring empties it
		put_line(DEPTH + 8, 1'b0);
		issue(OP_PEEK, 8'h00, 32'h0);
		issue(OP_SEEK, 8'h00, 32'h0);
		put_line(5, 1'b0);
		issue(OP_REWIND, 8'h00, 32'h0);
		issue(OP_CLEAR, 8'h00, 32'h0);

		// random: well-formed lines, some broken bytes, read bursts and single ops
		items = 0;
		paused = 1'b0;
		while (items < RANDOM_ITEMS) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 45)
				put_line($urandom_range(0, 30), $urandom_range(0, 5) == 0);
			else if (pick < 55)
				put(($urandom_range(0, 2) == 0) ? CH_CR : ($urandom_range(0, 1) ? CH_LF
					: 8'($urandom())));
			else if (pick < 65)
				repeat ($urandom_range(1, 10)) issue(OP_READ, $urandom(), $urandom());
			else
				single_op();
			if (!paused && items > RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_status.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire
